// ----- rtl/fdtm_pkg.sv -----
// Shared types and constants for the frequency-domain tap multiplier.
// No dependencies; imported by every module of the block.
`default_nettype none

package fdtm_pkg;

	localparam int unsigned DATA_W    = 16;
	localparam int unsigned PROD_W    = 2 * DATA_W;
	localparam int unsigned SUM_W     = PROD_W + 1;
	localparam int unsigned TAP_DEPTH = 512;
	localparam int unsigned TAP_AW    = $clog2(TAP_DEPTH);

	// Item function codes.
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_DATA = 1'b1;

	typedef logic signed [DATA_W-1:0] sample_t;
	typedef logic [TAP_AW-1:0]        tap_addr_t;

	// Packed so that the real part sits in the low half of the word.
	typedef struct packed {
		sample_t im;
		sample_t re;
	} tap_t;

	// One data sample with its tap, as handed to the multiplier.
	typedef struct packed {
		sample_t d_re;
		sample_t d_im;
		tap_t    tap;
		logic    last;
	} cmul_in_t;

endpackage : fdtm_pkg

`default_nettype wire

// ----- rtl/fdtm_tap_ram.sv -----
// Coefficient store: one write port, one read port with registered data.
// Depends on fdtm_pkg for the address and word types.
`default_nettype none

module fdtm_tap_ram (
	input  wire                clk,
	input  wire                wr_en,
	input  fdtm_pkg::tap_addr_t wr_addr,
	input  fdtm_pkg::tap_t      wr_data,
	input  wire                rd_en,
	input  fdtm_pkg::tap_addr_t rd_addr,
	output fdtm_pkg::tap_t      rd_data
);
	import fdtm_pkg::*;

	tap_t mem [TAP_DEPTH];
	tap_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule : fdtm_tap_ram

`default_nettype wire

// ----- rtl/fdtm_cmul.sv -----
// Complex multiply pipeline: products, sums, then round-half-even and saturate.
// Depends on fdtm_pkg; three stages, each with its own hold under stall.
`default_nettype none

module fdtm_cmul #(
	parameter int unsigned SHIFT = 15
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  fdtm_pkg::cmul_in_t   in_data,
	output logic                 res_valid,
	input  wire                  res_stall,
	output fdtm_pkg::sample_t    res_re,
	output fdtm_pkg::sample_t    res_im,
	output logic                 res_last
);
	import fdtm_pkg::*;

	localparam logic [SUM_W:0]        RMASK   = ((SUM_W+1)'(1) << SHIFT) - (SUM_W+1)'(1);
	localparam logic [SUM_W:0]        HALF    = ((SUM_W+1)'(1) << SHIFT) >> 1;
	localparam logic signed [SUM_W:0] SAT_MAX = (SUM_W+1)'(32767);
	localparam logic signed [SUM_W:0] SAT_MIN = -(SUM_W+1)'(32768);

	// Floor shift plus a round-up decision gives round half to even.
	function automatic sample_t round_sat(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W:0] ext;
		logic signed [SUM_W:0] q;
		logic [SUM_W:0]        rem;
		logic                  up;
		ext = {v[SUM_W-1], v};
		q   = ext >>> SHIFT;
		rem = ext & RMASK;
		up  = (HALF != '0) && ((rem > HALF) || ((rem == HALF) && q[0]));
		q   = q + (SUM_W+1)'(up);
		if (q > SAT_MAX) begin
			return sample_t'(SAT_MAX);
		end else if (q < SAT_MIN) begin
			return sample_t'(SAT_MIN);
		end
		return sample_t'(q);
	endfunction

	logic en2, en3, en4;

	logic                     valid_s2, last_s2;
	logic signed [PROD_W-1:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2;
	logic                     valid_s3, last_s3;
	logic signed [SUM_W-1:0]  sum_re_s3, sum_im_s3;
	logic                     valid_s4, last_s4;
	sample_t                  re_s4, im_s4;

	assign en4      = !valid_s4 || !res_stall;
	assign en3      = !valid_s3 || en4;
	assign en2      = !valid_s2 || en3;
	assign in_stall = !en2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en2) valid_s2 <= in_valid;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			p_rr_s2 <= PROD_W'(in_data.d_re) * PROD_W'(in_data.tap.re);
			p_ii_s2 <= PROD_W'(in_data.d_im) * PROD_W'(in_data.tap.im);
			p_ri_s2 <= PROD_W'(in_data.d_re) * PROD_W'(in_data.tap.im);
			p_ir_s2 <= PROD_W'(in_data.d_im) * PROD_W'(in_data.tap.re);
			last_s2 <= in_data.last;
		end
		if (en3) begin
			sum_re_s3 <= SUM_W'(p_rr_s2) - SUM_W'(p_ii_s2);
			sum_im_s3 <= SUM_W'(p_ri_s2) + SUM_W'(p_ir_s2);
			last_s3   <= last_s2;
		end
		if (en4) begin
			re_s4   <= round_sat(sum_re_s3);
			im_s4   <= round_sat(sum_im_s3);
			last_s4 <= last_s3;
		end
	end

	assign res_valid = valid_s4;
	assign res_re    = re_s4;
	assign res_im    = im_s4;
	assign res_last  = last_s4;

endmodule : fdtm_cmul

`default_nettype wire

// ----- rtl/frequency_domain_tap_multiply.sv -----
// A sample goes through stage 1, then the product, sum and rounding stages.
// Throughput: one item per cycle unless stalled; loads and samples may be back to back.
// Bubbles in the pipeline are taken up while a result waits on result_stall.
// Reset clears the bin counter and all valid flags; the tap memory is not
// cleared and must be loaded before its entries are used.
`default_nettype none

module frequency_domain_tap_multiply #(
	parameter int unsigned BINS  = 512,
	parameter int unsigned SHIFT = 15
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               sample_valid,
	output logic              sample_stall,
	input  wire               func,
	input  wire  [8:0]        tap_index,
	input  fdtm_pkg::sample_t value_re,
	input  fdtm_pkg::sample_t value_im,
	output logic              result_valid,
	input  wire               result_stall,
	output fdtm_pkg::sample_t out_re,
	output fdtm_pkg::sample_t out_im,
	output logic              frame_end
);
	import fdtm_pkg::*;

	localparam int unsigned BIN_W = $clog2(BINS);
	localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(BINS - 1);

	logic             en1, accept, cmul_stall, is_last;
	logic [BIN_W-1:0] bin_q;
	tap_t             tap_rd;
	cmul_in_t         cmul_in;

	logic    valid_s1, last_s1;
	sample_t d_re_s1, d_im_s1;

	assign en1          = !valid_s1 || !cmul_stall;
	assign sample_stall = !en1;
	assign accept       = sample_valid && en1;
	assign is_last      = (bin_q == LAST_BIN);

	// A load writes at its own edge, so a sample right behind it reads the new tap.
	fdtm_tap_ram u_tap_ram (
		.clk     (clk),
		.wr_en   (accept && (func == FUNC_LOAD)),
		.wr_addr (tap_index),
		.wr_data ({value_im, value_re}),
		.rd_en   (en1),
		.rd_addr (TAP_AW'(bin_q)),
		.rd_data (tap_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1 <= accept && (func == FUNC_DATA);
			end
			if (accept && (func == FUNC_DATA)) begin
				bin_q <= is_last ? '0 : bin_q + BIN_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			d_re_s1 <= value_re;
			d_im_s1 <= value_im;
			last_s1 <= is_last;
		end
	end

	assign cmul_in.d_re = d_re_s1;
	assign cmul_in.d_im = d_im_s1;
	assign cmul_in.tap  = tap_rd;
	assign cmul_in.last = last_s1;

	fdtm_cmul #(
		.SHIFT (SHIFT)
	) u_cmul (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_stall  (cmul_stall),
		.in_data   (cmul_in),
		.res_valid (result_valid),
		.res_stall (result_stall),
		.res_re    (out_re),
		.res_im    (out_im),
		.res_last  (frame_end)
	);

`ifndef SYNTHESIS
	a_bin_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		bin_q <= LAST_BIN)
		else $error("bin counter beyond the frame");

	a_load_holds_bin: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (func == FUNC_LOAD)) |=> $stable(bin_q))
		else $error("load transaction moved the bin counter");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (func == FUNC_DATA) && is_last) |=> (bin_q == '0) && last_s1)
		else $error("frame end did not wrap the bin counter");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && cmul_stall) |=> valid_s1 && $stable(tap_rd))
		else $error("stage 1 tap changed while stalled");
`endif

endmodule : frequency_domain_tap_multiply

`default_nettype wire

// ----- bench/fdtm_product_checker.sv -----
// Checker for the frequency-domain tap multiplier: watches both channels, predicts
// each product from its own copy of the tap memory and bin counter, and compares.
// Depends on fdtm_pkg for the sample and tap types and the function codes.
`timescale 1ns / 100ps

module fdtm_product_checker #(
	parameter int unsigned BINS  = 512,
	parameter int unsigned SHIFT = 15
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  sample_valid,
	input  wire                  sample_stall,
	input  wire                  func,
	input  wire  [8:0]           tap_index,
	input  fdtm_pkg::sample_t    value_re,
	input  fdtm_pkg::sample_t    value_im,
	input  wire                  result_valid,
	input  wire                  result_stall,
	input  fdtm_pkg::sample_t    out_re,
	input  fdtm_pkg::sample_t    out_im,
	input  wire                  frame_end,
	output int                   fail_count,
	output int                   pending,
	output int                   products_checked,
	output int                   frames_checked
);
	import fdtm_pkg::*;

	localparam int MAX_PRINTED = 25;

	typedef struct packed {
		sample_t re;
		sample_t im;
		logic    last;
	} product_t;

	tap_t        tap_mem [TAP_DEPTH];
	int unsigned bin_index;
	product_t    expected_products [$];
	product_t    want;

	// Drops the SHIFT low bits with round-half-to-even, then clamps to 16 bits.
	function automatic sample_t scale_round_sat(longint acc);
		longint q;
		longint rem;
		longint half;
		if (SHIFT == 0) begin
			q = acc;
		end else begin
			q = acc >>> SHIFT;
			rem = acc - (q <<< SHIFT);
			half = longint'(1) <<< (SHIFT - 1);
			if (rem > half || (rem == half && q[0]))
				q = q + 1;
		end
		if (q > 32767)
			q = 32767;
		else if (q < -32768)
			q = -32768;
		return sample_t'(q);
	endfunction

	function automatic product_t tap_product(sample_t d_re, sample_t d_im, tap_t tap,
			logic last);
		longint p_re;
		longint p_im;
		product_t p;
		p_re = longint'(d_re) * longint'(tap.re) - longint'(d_im) * longint'(tap.im);
		p_im = longint'(d_re) * longint'(tap.im) + longint'(d_im) * longint'(tap.re);
		p.re = scale_round_sat(p_re);
		p.im = scale_round_sat(p_im);
		p.last = last;
		return p;
	endfunction

	task automatic report_mismatch(string what, logic signed [15:0] got,
			logic signed [15:0] expected);
		fail_count++;
		if (fail_count <= MAX_PRINTED)
			$display("%0t ns: %s: got %0d, expected %0d", $realtime, what, got, expected);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_products.delete();
			bin_index = 0;
			fail_count = 0;
			products_checked = 0;
			frames_checked = 0;
			pending <= 0;
		end else begin
			if (sample_valid && !sample_stall) begin
				if (func == FUNC_LOAD) begin
					tap_mem[tap_index].re = value_re;
					tap_mem[tap_index].im = value_im;
				end else begin
					// Bins past the end of the store wrap onto its low address bits.
					expected_products.push_back(tap_product(value_re, value_im,
						tap_mem[bin_index % TAP_DEPTH], bin_index >= BINS - 1));
					bin_index = (bin_index >= BINS - 1) ? 0 : bin_index + 1;
				end
			end
			if (result_valid && !result_stall) begin
				if (expected_products.size() == 0) begin
					report_mismatch("product with no sample waiting, out_re", out_re, 0);
				end else begin
					want = expected_products.pop_front();
					if (out_re !== want.re)
						report_mismatch("out_re", out_re, want.re);
					if (out_im !== want.im)
						report_mismatch("out_im", out_im, want.im);
					if (frame_end !== want.last)
						report_mismatch("frame_end", frame_end, want.last);
					products_checked++;
					if (want.last)
						frames_checked++;
				end
			end
			pending <= expected_products.size();
		end
	end

endmodule : fdtm_product_checker

// ----- bench/frequency_domain_tap_multiply_tb.sv -----
// Top of the tap multiplier bench: clock, reset, sample stimulus and result back-pressure.
// Depends on fdtm_pkg, frequency_domain_tap_multiply and fdtm_product_checker.
`timescale 1ns / 100ps

module frequency_domain_tap_multiply_tb;
	import fdtm_pkg::*;

	localparam int unsigned BINS           = 512;
	localparam int unsigned SHIFT          = 15;
	localparam int          ITEMS          = 1600;
	localparam int          CYCLE_LIMIT    = 200000;
	localparam int          HOLDOFF_CYCLES = 300;
	localparam int          DRAIN_CYCLES   = 20;
	localparam logic [7:0]  STALL_PATTERN  = 8'b1011_0010;
	localparam sample_t     MOST_NEG       = 16'sh8000;
	localparam sample_t     MOST_POS       = 16'sh7FFF;
	localparam sample_t     HALF           = 16'sh4000;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    sample_valid;
	logic    sample_stall;
	logic    func;
	logic    [8:0] tap_index;
	sample_t value_re;
	sample_t value_im;
	logic    result_valid;
	logic    result_stall;
	sample_t out_re;
	sample_t out_im;
	logic    frame_end;

	int fail_count;
	int pending;
	int products_checked;
	int frames_checked;
	int cycle_count = 0;

	bit          tap_written [TAP_DEPTH];
	int unsigned next_bin = 0;
	int          burst_left = 0;
	int          loads_sent = 0;
	int          samples_sent = 0;
	bit          holdoff_req = 1'b0;
	bit          holdoff_done = 1'b0;

	frequency_domain_tap_multiply #(
		.BINS  (BINS),
		.SHIFT (SHIFT)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.func         (func),
		.tap_index    (tap_index),
		.value_re     (value_re),
		.value_im     (value_im),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_re       (out_re),
		.out_im       (out_im),
		.frame_end    (frame_end)
	);

	fdtm_product_checker #(
		.BINS  (BINS),
		.SHIFT (SHIFT)
	) product_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.sample_valid     (sample_valid),
		.sample_stall     (sample_stall),
		.func             (func),
		.tap_index        (tap_index),
		.value_re         (value_re),
		.value_im         (value_im),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.out_re           (out_re),
		.out_im           (out_im),
		.frame_end        (frame_end),
		.fail_count       (fail_count),
		.pending          (pending),
		.products_checked (products_checked),
		.frames_checked   (frames_checked)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d products outstanding",
				cycle_count, pending);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Mostly full-range values, with the corners of the Q15 range mixed in.
	function automatic sample_t rand_value();
		case ($urandom_range(0, 11))
			0: return MOST_NEG;
			1: return MOST_POS;
			2: return sample_t'(0);
			3: return sample_t'(-1);
			4: return HALF;
			default: return sample_t'($urandom);
		endcase
	endfunction

	// Offers one transaction and returns at the edge that accepts it. Bursts of
	// back-to-back transactions are mostly separated by random idle gaps.
	task automatic send_item(logic f, tap_addr_t idx, sample_t re, sample_t im);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				sample_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 20);
		end
		burst_left--;
		sample_valid <= 1'b1;
		func <= f;
		tap_index <= idx;
		value_re <= re;
		value_im <= im;
		do @(posedge clk); while (sample_stall);
	endtask

	task automatic load_tap(tap_addr_t idx, sample_t re, sample_t im);
		send_item(FUNC_LOAD, idx, re, im);
		tap_written[idx] = 1'b1;
		loads_sent++;
	endtask

	// A sample never reads an unwritten tap: its bin gets a coefficient first.
	task automatic send_sample(sample_t re, sample_t im);
		tap_addr_t bin_addr;
		bin_addr = tap_addr_t'(next_bin % TAP_DEPTH);
		if (!tap_written[bin_addr])
			load_tap(bin_addr, rand_value(), rand_value());
		send_item(FUNC_DATA, tap_addr_t'($urandom_range(0, TAP_DEPTH - 1)), re, im);
		next_bin = (next_bin >= BINS - 1) ? 0 : next_bin + 1;
		samples_sent++;
	endtask

	initial begin
		arst_n = 1'b0;
		sample_valid = 1'b0;
		func = FUNC_LOAD;
		tap_index = '0;
		value_re = '0;
		value_im = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Taps for the first bins, loaded in a row and between samples so
		// that loads are seen not to move the bin counter.
		load_tap(0, MOST_NEG, MOST_NEG);
		load_tap(1, MOST_NEG, 0);
		load_tap(2, HALF, 0);
		load_tap(3, MOST_POS, MOST_POS);
		// Full-scale products: (-1)*(-1) terms saturate to the positive limit.
		send_sample(MOST_NEG, MOST_NEG);
		send_sample(MOST_NEG, 0);
		load_tap(4, 0, MOST_NEG);
		load_tap(5, HALF, 0);
		load_tap(6, HALF, 0);
		// Exact halves round to the even neighbor: 0.5 -> 0, 1.5 -> 2, -0.5 -> 0.
		send_sample(1, 0);
		send_sample(MOST_NEG, MOST_POS);
		send_sample(MOST_POS, -1);
		send_sample(3, 0);
		send_sample(-1, 0);
		// Two highest addresses, stored well before their bins come around.
		load_tap(TAP_DEPTH - 1, 16'sh5555, 16'shAAAA);
		load_tap(TAP_DEPTH - 2, 16'shAAAA, 16'sh5555);

		holdoff_req = 1'b1;
		while (loads_sent + samples_sent < ITEMS) begin
			if ($urandom_range(0, 4) == 0)
				load_tap(tap_addr_t'($urandom_range(0, TAP_DEPTH - 1)), rand_value(),
					rand_value());
			else
				send_sample(rand_value(), rand_value());
		end
		sample_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Drove %0d coefficient loads and %0d samples; %0d products checked, %0d frame ends.",
			loads_sent, samples_sent, products_checked, frames_checked);
		$display("Result side was held off once for %0d cycles while samples kept coming.",
			HOLDOFF_CYCLES);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Result back-pressure: stretches of no stall, light and heavy random stall and
	// a fixed rotating pattern, plus one long hold-off once random traffic starts.
	initial begin
		int mode;
		int len;
		int unsigned phase;
		result_stall = 1'b0;
		phase = 0;
		wait (arst_n);
		forever begin
			if (holdoff_req && !holdoff_done) begin
				holdoff_done = 1'b1;
				repeat (HOLDOFF_CYCLES) begin
					@(posedge clk);
					result_stall <= 1'b1;
				end
			end
			mode = $urandom_range(0, 3);
			len = $urandom_range(5, 60);
			repeat (len) begin
				@(posedge clk);
				case (mode)
					0: result_stall <= 1'b0;
					1: result_stall <= ($urandom_range(0, 3) == 0);
					2: result_stall <= ($urandom_range(0, 1) == 0);
					default: begin
						result_stall <= STALL_PATTERN[phase % 8];
						phase++;
					end
				endcase
			end
		end
	end

endmodule : frequency_domain_tap_multiply_tb

// ----- sim.f -----
rtl/fdtm_pkg.sv
rtl/fdtm_tap_ram.sv
rtl/fdtm_cmul.sv
rtl/frequency_domain_tap_multiply.sv
bench/fdtm_product_checker.sv
bench/frequency_domain_tap_multiply_tb.sv
